FILE: src/tbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tournament branch predictor - shared definitions
// Table geometry, counter codes, payload types and the saturating counter step.
// ----------------------------------------------------------------------------
package tbp_pkg;

  // Table geometry
  localparam int PC_INDEX_BITS       = 12;
  localparam int LOCAL_HISTORY_BITS  = 10;
  localparam int GLOBAL_HISTORY_BITS = 11;
  localparam int PC_WIDTH            = 32;

  localparam int LHT_DEPTH = 1 << PC_INDEX_BITS;
  localparam int LCT_DEPTH = 1 << LOCAL_HISTORY_BITS;
  localparam int GCT_DEPTH = 1 << GLOBAL_HISTORY_BITS;

  // Clear sweep covers the deepest table; shallower ones take the low bits
  localparam int CLR_BITS_LG = (PC_INDEX_BITS > LOCAL_HISTORY_BITS) ?
                               PC_INDEX_BITS : LOCAL_HISTORY_BITS;
  localparam int CLR_BITS    = (CLR_BITS_LG > GLOBAL_HISTORY_BITS) ?
                               CLR_BITS_LG : GLOBAL_HISTORY_BITS;

  // Result queue; depth must be a power of two (pointers wrap naturally)
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // Counter width and codes
  localparam int CTR_W = 2;
  typedef logic [CTR_W-1:0] ctr_t;
  localparam ctr_t CTR_MIN   = 2'd0;
  localparam ctr_t CTR_WEAK  = 2'd1;
  localparam ctr_t CTR_MAX   = 2'd3;

  // Item function codes
  localparam logic FUNC_PREDICT = 1'b0;
  localparam logic FUNC_TRAIN   = 1'b1;

  typedef logic [PC_WIDTH-1:0]            pc_t;
  typedef logic [PC_INDEX_BITS-1:0]       slot_t;
  typedef logic [LOCAL_HISTORY_BITS-1:0]  lhist_t;
  typedef logic [GLOBAL_HISTORY_BITS-1:0] ghist_t;
  typedef logic [CLR_BITS-1:0]            clr_addr_t;

  // Record of the table write done at the last clock edge
  typedef struct packed {
    logic   valid;
    slot_t  addr;
    lhist_t data;
  } lht_wr_t;

  typedef struct packed {
    logic   valid;
    lhist_t addr;
    ctr_t   data;
  } lct_wr_t;

  typedef struct packed {
    logic   valid;
    ghist_t addr;
    ctr_t   data;
  } gct_wr_t;

  // Step a 2-bit counter up or down, stopping at both ends
  function automatic ctr_t sat_move(input ctr_t c, input logic up);
    ctr_t r;
    if (up) begin
      r = (c == CTR_MAX) ? c : ctr_t'(c + 1'b1);
    end else begin
      r = (c == CTR_MIN) ? c : ctr_t'(c - 1'b1);
    end
    return r;
  endfunction

endpackage

FILE: src/tbp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tournament branch predictor - request channel
// Valid/ready channel carrying one branch word: function, address, outcome.
// ----------------------------------------------------------------------------
interface tbp_in_if;
  import tbp_pkg::*;

  logic valid;
  logic ready;
  logic func;
  pc_t  pc;
  logic outcome;

  modport source (output valid, output func, output pc, output outcome, input ready);
  modport sink   (input valid, input func, input pc, input outcome, output ready);

endinterface

FILE: src/tbp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tournament branch predictor - result channel
// Valid/ready channel carrying one prediction word.
// ----------------------------------------------------------------------------
interface tbp_out_if;

  logic valid;
  logic ready;
  logic prediction;

  modport source (output valid, output prediction, input ready);
  modport sink   (input valid, input prediction, output ready);

endinterface

FILE: src/tournament_branch_predictor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tournament branch predictor unit
// Local/global predictor with a chooser table, one branch word per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one word per branch: func (predict only / train), pc and the
//              resolved outcome. Only the low PC_INDEX_BITS of pc are used.
//   out_chan : one prediction word for every accepted word, in order, formed
//              from the table state before that word's own training.
//   Throughput: one word per cycle while in_chan.ready is high. Each table is
//   read once per word and written at most once, by train words only, and
//   back-to-back hazards are covered by bypassing the last write. A word
//   passes the two table stages, then the result queue, to reach out_chan.
//   Reset: after rst_n is released the tables are swept one entry per cycle,
//   2^CLR_BITS entries (4096 by default); in_chan.ready stays low meanwhile.
//   Stall: results wait in a four-word queue; in_chan.ready drops when four
//   words are accepted and not yet delivered, so no result is ever dropped.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_unit (
  input  logic         clk,
  input  logic         rst_n,
  tbp_in_if.sink       in_chan,
  tbp_out_if.source    out_chan
);
  import tbp_pkg::*;

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  logic                clr_active_r;
  clr_addr_t           clr_addr_r;

  logic                in_acc;
  logic                out_pop;
  logic [OQ_CNT_W-1:0] credit_r, credit_nxt;

  ghist_t              ghist_r, ghist_nxt;

  logic                s1_valid_r;
  logic                s1_train_r;
  logic                s1_taken_r;
  slot_t               s1_slot_r;
  ghist_t              s1_gidx_r;

  logic                s2_valid_r;
  logic                s2_train_r;
  logic                s2_taken_r;
  ghist_t              s2_gidx_r;
  lhist_t              s2_lidx_r;
  ctr_t                s2_gct_r;
  ctr_t                s2_cht_r;

  lht_wr_t             lht_wl_r;
  lct_wr_t             lct_wl_r;
  gct_wr_t             gct_wl_r;
  gct_wr_t             cht_wl_r;

  lhist_t              lht_q;
  ctr_t                lct_q, gct_q, cht_q;

  lhist_t              s1_lhist;
  lhist_t              s1_lhist_new;
  ctr_t                s1_gct, s1_cht;
  logic                s1_lht_we;

  ctr_t                s2_lct, s2_gct, s2_cht;
  logic                s2_lpred, s2_gpred, s2_pred, s2_disagree;
  logic                s2_we;
  ctr_t                s2_lct_new, s2_gct_new, s2_cht_new;

  logic                lht_we, lct_we, gct_we, cht_we;
  slot_t               lht_waddr;
  lhist_t              lht_wdata, lct_waddr;
  ghist_t              gct_waddr, cht_waddr;
  ctr_t                lct_wdata, gct_wdata, cht_wdata;

  logic                oq_mem_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wptr_r, oq_rptr_r;
  logic [OQ_CNT_W-1:0] oq_cnt_r;

  // --------------------------------------------------------------------------
  // Handshake and credit: words in flight plus queued never exceed the queue
  // --------------------------------------------------------------------------
  assign in_chan.ready  = !clr_active_r && (credit_r < OQ_CNT_W'(OQ_DEPTH));
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign out_pop        = out_chan.valid && out_chan.ready;

  always_comb begin
    credit_nxt = credit_r;
    if (in_acc && !out_pop) begin
      credit_nxt = OQ_CNT_W'(credit_r + 1'b1);
    end else if (!in_acc && out_pop) begin
      credit_nxt = OQ_CNT_W'(credit_r - 1'b1);
    end
  end

  // Shift the global history as soon as a train word is taken
  assign ghist_nxt = (in_acc && (in_chan.func == FUNC_TRAIN)) ?
                     ghist_t'({ghist_r, in_chan.outcome}) : ghist_r;

  // --------------------------------------------------------------------------
  // Clear sweep after reset
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_t'(clr_addr_r + 1'b1);
      if (clr_addr_r == '1) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tables
  // --------------------------------------------------------------------------
  tbp_ram #(.WIDTH(LOCAL_HISTORY_BITS), .DEPTH(LHT_DEPTH)) u_lht (
    .clk   (clk),
    .we    (lht_we),
    .waddr (lht_waddr),
    .wdata (lht_wdata),
    .raddr (slot_t'(in_chan.pc)),
    .rdata (lht_q)
  );

  tbp_ram #(.WIDTH(CTR_W), .DEPTH(LCT_DEPTH)) u_lct (
    .clk   (clk),
    .we    (lct_we),
    .waddr (lct_waddr),
    .wdata (lct_wdata),
    .raddr (s1_lhist),
    .rdata (lct_q)
  );

  tbp_ram #(.WIDTH(CTR_W), .DEPTH(GCT_DEPTH)) u_gct (
    .clk   (clk),
    .we    (gct_we),
    .waddr (gct_waddr),
    .wdata (gct_wdata),
    .raddr (ghist_r),
    .rdata (gct_q)
  );

  tbp_ram #(.WIDTH(CTR_W), .DEPTH(GCT_DEPTH)) u_cht (
    .clk   (clk),
    .we    (cht_we),
    .waddr (cht_waddr),
    .wdata (cht_wdata),
    .raddr (ghist_r),
    .rdata (cht_q)
  );

  // --------------------------------------------------------------------------
  // Stage 1: local history lookup, global and chooser reads, bypass of the write made at the last edge
  // --------------------------------------------------------------------------
  always_comb begin
    s1_lhist = lht_q;
    if (lht_wl_r.valid && (lht_wl_r.addr == s1_slot_r)) begin
      s1_lhist = lht_wl_r.data;
    end
    s1_gct = gct_q;
    if (gct_wl_r.valid && (gct_wl_r.addr == s1_gidx_r)) begin
      s1_gct = gct_wl_r.data;
    end
    s1_cht = cht_q;
    if (cht_wl_r.valid && (cht_wl_r.addr == s1_gidx_r)) begin
      s1_cht = cht_wl_r.data;
    end
  end

  assign s1_lhist_new = lhist_t'({s1_lhist, s1_taken_r});
  assign s1_lht_we    = s1_valid_r && s1_train_r;

  // --------------------------------------------------------------------------
  // Stage 2: counters, chooser, prediction and training
  // --------------------------------------------------------------------------
  always_comb begin
    s2_lct = lct_q;
    if (lct_wl_r.valid && (lct_wl_r.addr == s2_lidx_r)) begin
      s2_lct = lct_wl_r.data;
    end
    s2_gct = s2_gct_r;
    if (gct_wl_r.valid && (gct_wl_r.addr == s2_gidx_r)) begin
      s2_gct = gct_wl_r.data;
    end
    s2_cht = s2_cht_r;
    if (cht_wl_r.valid && (cht_wl_r.addr == s2_gidx_r)) begin
      s2_cht = cht_wl_r.data;
    end
  end

  assign s2_lpred    = s2_lct[CTR_W-1];
  assign s2_gpred    = s2_gct[CTR_W-1];
  assign s2_disagree = (s2_lpred != s2_gpred);
  // Chooser upper half picks the global prediction
  assign s2_pred     = (s2_disagree && s2_cht[CTR_W-1]) ? s2_gpred : s2_lpred;

  assign s2_we       = s2_valid_r && s2_train_r;
  assign s2_lct_new  = sat_move(s2_lct, s2_taken_r);
  assign s2_gct_new  = sat_move(s2_gct, s2_taken_r);
  assign s2_cht_new  = sat_move(s2_cht, s2_taken_r == s2_gpred);

  // --------------------------------------------------------------------------
  // Table write ports: clear sweep or training
  // --------------------------------------------------------------------------
  always_comb begin
    if (clr_active_r) begin
      lht_we    = 1'b1;
      lht_waddr = clr_addr_r[PC_INDEX_BITS-1:0];
      lht_wdata = '0;
      lct_we    = 1'b1;
      lct_waddr = clr_addr_r[LOCAL_HISTORY_BITS-1:0];
      lct_wdata = CTR_WEAK;
      gct_we    = 1'b1;
      gct_waddr = clr_addr_r[GLOBAL_HISTORY_BITS-1:0];
      gct_wdata = CTR_WEAK;
      cht_we    = 1'b1;
      cht_waddr = clr_addr_r[GLOBAL_HISTORY_BITS-1:0];
      cht_wdata = CTR_WEAK;
    end else begin
      lht_we    = s1_lht_we;
      lht_waddr = s1_slot_r;
      lht_wdata = s1_lhist_new;
      lct_we    = s2_we;
      lct_waddr = s2_lidx_r;
      lct_wdata = s2_lct_new;
      gct_we    = s2_we;
      gct_waddr = s2_gidx_r;
      gct_wdata = s2_gct_new;
      cht_we    = s2_we && s2_disagree;
      cht_waddr = s2_gidx_r;
      cht_wdata = s2_cht_new;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline and bypass registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r       <= '0;
      ghist_r        <= '0;
      s1_valid_r     <= 1'b0;
      s2_valid_r     <= 1'b0;
      lht_wl_r.valid <= 1'b0;
      lct_wl_r.valid <= 1'b0;
      gct_wl_r.valid <= 1'b0;
      cht_wl_r.valid <= 1'b0;
    end else begin
      credit_r       <= credit_nxt;
      ghist_r        <= ghist_nxt;
      s1_valid_r     <= in_acc;
      s2_valid_r     <= s1_valid_r;
      lht_wl_r.valid <= s1_lht_we;
      lct_wl_r.valid <= s2_we;
      gct_wl_r.valid <= s2_we;
      cht_wl_r.valid <= s2_we && s2_disagree;
      lht_wl_r.addr  <= s1_slot_r;
      lht_wl_r.data  <= s1_lhist_new;
      lct_wl_r.addr  <= s2_lidx_r;
      lct_wl_r.data  <= s2_lct_new;
      gct_wl_r.addr  <= s2_gidx_r;
      gct_wl_r.data  <= s2_gct_new;
      cht_wl_r.addr  <= s2_gidx_r;
      cht_wl_r.data  <= s2_cht_new;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    s1_train_r    <= (in_chan.func == FUNC_TRAIN);
    s1_taken_r    <= in_chan.outcome;
    s1_slot_r     <= slot_t'(in_chan.pc);
    s1_gidx_r     <= ghist_r;

    s2_train_r    <= s1_train_r;
    s2_taken_r    <= s1_taken_r;
    s2_gidx_r     <= s1_gidx_r;
    s2_lidx_r     <= s1_lhist;
    s2_gct_r      <= s1_gct;
    s2_cht_r      <= s1_cht;
  end

  // --------------------------------------------------------------------------
  // Result queue: push every stage-2 word, pop on the output handshake
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wptr_r <= '0;
      oq_rptr_r <= '0;
      oq_cnt_r  <= '0;
    end else begin
      if (s2_valid_r) begin
        oq_wptr_r <= OQ_PTR_W'(oq_wptr_r + 1'b1);
      end
      if (out_pop) begin
        oq_rptr_r <= OQ_PTR_W'(oq_rptr_r + 1'b1);
      end
      if (s2_valid_r && !out_pop) begin
        oq_cnt_r <= OQ_CNT_W'(oq_cnt_r + 1'b1);
      end else if (!s2_valid_r && out_pop) begin
        oq_cnt_r <= OQ_CNT_W'(oq_cnt_r - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      oq_mem_r[oq_wptr_r] <= s2_pred;
    end
  end

  assign out_chan.valid      = (oq_cnt_r != '0);
  assign out_chan.prediction = oq_mem_r[oq_rptr_r];

endmodule

FILE: src/tbp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tournament branch predictor - generic RAM
// One write port, one read port, registered read data, read-first on a
// same-address collision.
// ----------------------------------------------------------------------------
module tbp_ram #(
  parameter  int WIDTH  = 2,
  parameter  int DEPTH  = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write when we is set, read every cycle; the read returns the old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/tbp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tournament branch predictor - port checker
// Tracks accepted versus delivered words and checks reset and output behavior.
// ----------------------------------------------------------------------------
module tbp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_prediction
);
  import tbp_pkg::*;

  logic [OQ_CNT_W-1:0] outst_r;
  logic                acc;
  logic                pop;

  assign acc = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  // Count words accepted and not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outst_r <= '0;
    end else if (acc && !pop) begin
      outst_r <= OQ_CNT_W'(outst_r + 1'b1);
    end else if (!acc && pop) begin
      outst_r <= OQ_CNT_W'(outst_r - 1'b1);
    end
  end

  // Held result stays put while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_prediction))
    else $error("result changed or dropped while stalled");

  // Every result belongs to an accepted word
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> outst_r != '0)
    else $error("result without an accepted word");

  // A full queue of outstanding words blocks new input
  a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    outst_r == OQ_CNT_W'(OQ_DEPTH) |-> !in_ready)
    else $error("input taken with result queue full");

  // The clear sweep keeps input closed right after reset
  a_clear_block: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open during table clear");

endmodule

bind tournament_branch_predictor_unit tbp_checker u_tbp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_prediction (out_chan.prediction)
);
